### src/bmhpq_pkg.sv
// Shared types and codes for the binary min-heap priority queue.
package bmhpq_pkg;

  // Operation codes carried in the input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored heap entry.
  typedef struct packed {
    logic [15:0] node;
    logic [30:0] prio;
  } entry_t;

  // Input item.
  typedef struct packed {
    logic        operation;
    logic [15:0] entry_node;
    logic [30:0] entry_priority;
  } in_t;

  // Result item.
  typedef struct packed {
    status_t     status;
    logic [15:0] popped_node;
    logic [30:0] popped_priority;
    logic [10:0] occupancy;
  } out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_PO_ROOT,
    S_PO_LAST,
    S_PO_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_WR_CUR,
    S_FIN
  } state_t;

endpackage

### src/binary_min_heap_priority_queue.sv
// Top level of the bounded binary min-heap priority queue.
// A push stores (node, priority) and sifts it up; a pop returns the root entry and sifts the
// last entry down from the root; ties keep the parent, then prefer the left child. Entries live
// in one single-port-read, single-port-write memory with a registered read, and the
// moving entry is held in a register so that each level writes one slot. One item is worked on
// at a time: a push reads the parent and compares at each level climbed; a pop reads the root
// and the last entry, then reads the left child, the right child and compares at each level
// descended; a full push or an empty pop goes straight to the result. A finished result sits
// in an output register, so a stalled result does not block the next accepted item until
// that item is finished. Memory needs no clearing after reset.
module binary_min_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bmhpq_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bmhpq_pkg::out_t  out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Heap storage.
  bmhpq_pkg::entry_t heap_mem [CAPACITY];
  bmhpq_pkg::entry_t mem_rdata_r;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [IW-1:0]     mem_raddr;
  bmhpq_pkg::entry_t mem_wdata;

  // Control and datapath registers.
  bmhpq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  bmhpq_pkg::entry_t  cur_r, cur_nxt;
  bmhpq_pkg::entry_t  left_r, left_nxt;
  logic               has_right_r, has_right_nxt;
  bmhpq_pkg::status_t res_status_r, res_status_nxt;
  bmhpq_pkg::entry_t  res_entry_r, res_entry_nxt;
  logic               out_valid_r, out_valid_nxt;
  bmhpq_pkg::out_t    out_data_r, out_data_nxt;

  // Index arithmetic.
  logic          acc;
  logic          is_full;
  logic          out_free;
  logic [IW-1:0] pos_m1;
  logic [IW-1:0] parent_idx;
  logic [CW:0]   l_idx;
  logic [CW:0]   r_idx;
  logic [CW:0]   count_ext;
  logic          take_l;
  logic          take_r;
  logic [30:0]   best_prio;

  assign in_stall   = (state_r != bmhpq_pkg::S_IDLE);
  assign acc        = in_valid && !in_stall;
  assign is_full    = (count_r >= CW'(CAPACITY));
  assign out_free   = !out_valid_r || !out_stall;
  assign pos_m1     = pos_r - IW'(1);
  assign parent_idx = IW'(pos_m1 >> 1);
  assign l_idx      = (CW + 1)'({pos_r, 1'b1});
  assign r_idx      = l_idx + (CW + 1)'(1);
  assign count_ext  = {1'b0, count_r};
  assign take_l     = (left_r.prio < cur_r.prio);
  assign best_prio  = take_l ? left_r.prio : cur_r.prio;
  assign take_r     = has_right_r && (mem_rdata_r.prio < best_prio);

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= heap_mem[mem_raddr];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhpq_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data.operation == bmhpq_pkg::OP_PUSH) begin
            if (is_full) begin
              state_nxt = bmhpq_pkg::S_FIN;
            end else if (count_r == '0) begin
              state_nxt = bmhpq_pkg::S_WR_CUR;
            end else begin
              state_nxt = bmhpq_pkg::S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              state_nxt = bmhpq_pkg::S_FIN;
            end else begin
              state_nxt = bmhpq_pkg::S_PO_ROOT;
            end
          end
        end
      end
      bmhpq_pkg::S_UP_RD: begin
        state_nxt = bmhpq_pkg::S_UP_CMP;
      end
      bmhpq_pkg::S_UP_CMP: begin
        if (mem_rdata_r.prio > cur_r.prio) begin
          state_nxt = (parent_idx == '0) ? bmhpq_pkg::S_WR_CUR : bmhpq_pkg::S_UP_RD;
        end else begin
          state_nxt = bmhpq_pkg::S_FIN;
        end
      end
      bmhpq_pkg::S_PO_ROOT: begin
        state_nxt = bmhpq_pkg::S_PO_LAST;
      end
      bmhpq_pkg::S_PO_LAST: begin
        state_nxt = bmhpq_pkg::S_PO_LOAD;
      end
      bmhpq_pkg::S_PO_LOAD: begin
        state_nxt = (count_r == '0) ? bmhpq_pkg::S_FIN : bmhpq_pkg::S_DN_RDL;
      end
      bmhpq_pkg::S_DN_RDL: begin
        state_nxt = (l_idx < count_ext) ? bmhpq_pkg::S_DN_RDR : bmhpq_pkg::S_WR_CUR;
      end
      bmhpq_pkg::S_DN_RDR: begin
        state_nxt = bmhpq_pkg::S_DN_CMP;
      end
      bmhpq_pkg::S_DN_CMP: begin
        state_nxt = (take_l || take_r) ? bmhpq_pkg::S_DN_RDL : bmhpq_pkg::S_FIN;
      end
      bmhpq_pkg::S_WR_CUR: begin
        state_nxt = bmhpq_pkg::S_FIN;
      end
      bmhpq_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = bmhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bmhpq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result staging for each state.
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    has_right_nxt  = has_right_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = cur_r;
    mem_raddr      = '0;
    case (state_r)
      bmhpq_pkg::S_IDLE: begin
        if (acc) begin
          cur_nxt.node   = in_data.entry_node;
          cur_nxt.prio   = in_data.entry_priority;
          res_entry_nxt  = '0;
          res_status_nxt = bmhpq_pkg::ST_OK;
          if (in_data.operation == bmhpq_pkg::OP_PUSH) begin
            if (is_full) begin
              res_status_nxt = bmhpq_pkg::ST_FULL;
            end else begin
              pos_nxt   = count_r[IW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = bmhpq_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
      end
      bmhpq_pkg::S_UP_RD: begin
        mem_raddr = parent_idx;
      end
      bmhpq_pkg::S_UP_CMP: begin
        // Move the parent down into the hole, or settle the new entry here.
        mem_we = 1'b1;
        if (mem_rdata_r.prio > cur_r.prio) begin
          mem_wdata = mem_rdata_r;
          pos_nxt   = parent_idx;
        end
      end
      bmhpq_pkg::S_PO_ROOT: begin
        mem_raddr = '0;
      end
      bmhpq_pkg::S_PO_LAST: begin
        res_entry_nxt = mem_rdata_r;
        mem_raddr     = count_r[IW-1:0];
      end
      bmhpq_pkg::S_PO_LOAD: begin
        cur_nxt = mem_rdata_r;
        pos_nxt = '0;
      end
      bmhpq_pkg::S_DN_RDL: begin
        mem_raddr = l_idx[IW-1:0];
      end
      bmhpq_pkg::S_DN_RDR: begin
        left_nxt      = mem_rdata_r;
        has_right_nxt = (r_idx < count_ext);
        mem_raddr     = r_idx[IW-1:0];
      end
      bmhpq_pkg::S_DN_CMP: begin
        // Pull the smaller child up into the hole, or settle the moving entry here.
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = mem_rdata_r;
          pos_nxt   = r_idx[IW-1:0];
        end else if (take_l) begin
          mem_wdata = left_r;
          pos_nxt   = l_idx[IW-1:0];
        end
      end
      bmhpq_pkg::S_WR_CUR: begin
        mem_we = 1'b1;
      end
      bmhpq_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = res_status_r;
          out_data_nxt.popped_node     = res_entry_r.node;
          out_data_nxt.popped_priority = res_entry_r.prio;
          out_data_nxt.occupancy       = 11'(count_r);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmhpq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    left_r       <= left_nxt;
    has_right_r  <= has_right_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/bmhpq_chk.sv
// Port-level checker for the binary min-heap priority queue, with its bind statement.
module bmhpq_chk #(
  parameter int CAPACITY = 1024
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input bmhpq_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input bmhpq_pkg::out_t out_data
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One item at a time: an accepted transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in progress");

  // A dropped push reports a full heap and no popped entry.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bmhpq_pkg::ST_FULL) |->
      (out_data.occupancy == 11'(CAPACITY)) && (out_data.popped_node == '0) &&
      (out_data.popped_priority == '0))
    else $error("full status with inconsistent result");

  // A pop on an empty heap reports zero occupancy and no popped entry.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bmhpq_pkg::ST_EMPTY) |->
      (out_data.occupancy == '0) && (out_data.popped_node == '0) &&
      (out_data.popped_priority == '0))
    else $error("empty status with inconsistent result");

endmodule

bind binary_min_heap_priority_queue bmhpq_chk #(.CAPACITY(CAPACITY)) u_bmhpq_chk (.*);
